@@ rtl/lltm_pkg.sv @@
// Package for the LCD line and mode timer: shared types, timing constants
// and register codes. No dependencies.
package lltm_pkg;

  // Line timing
  localparam int DOTS_PER_LINE = 456;
  localparam int VISIBLE_LINES = 144;
  localparam int LAST_LINE     = 153;
  localparam int OAM_SCAN_END  = 80;
  localparam int DRAW_END      = 252;

  // Field widths
  localparam int ELAPSED_W = 8;
  localparam int DOT_W     = 9;
  localparam int LINE_W    = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;
  localparam int STAT_W    = 4;
  localparam int OUT_W     = 16;

  // Status interrupt enable bit positions
  localparam int STAT_EN_HBLANK = 0;
  localparam int STAT_EN_VBLANK = 1;
  localparam int STAT_EN_OAM    = 2;
  localparam int STAT_EN_MATCH  = 3;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LCD_ENABLE   = 2'd0,
    CFG_LYC_VALUE    = 2'd1,
    CFG_STAT_ENABLES = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic              lcd_enable;
    logic [LINE_W-1:0] lyc_value;
    logic [STAT_W-1:0] stat_enables;
  } cfg_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_number;
    mode_t             lcd_mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              frame_done;
    logic              line_started;
  } result_t;

endpackage

@@ rtl/lltm_cfg_regs.sv @@
// Configuration registers of the LCD line and mode timer.
// Depends on lltm_pkg.
module lltm_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [lltm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lltm_pkg::CFG_DAT_W-1:0] cfg_data,
  output lltm_pkg::cfg_t                cfg
);
  import lltm_pkg::*;

  cfg_t cfg_r;

  // Decode the index and load the addressed register; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lcd_enable   <= 1'b1;
      cfg_r.lyc_value    <= '0;
      cfg_r.stat_enables <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_LCD_ENABLE:   cfg_r.lcd_enable   <= cfg_data[0];
        CFG_LYC_VALUE:    cfg_r.lyc_value    <= cfg_data[LINE_W-1:0];
        CFG_STAT_ENABLES: cfg_r.stat_enables <= cfg_data[STAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/lltm_in_reg.sv @@
// Input register of the LCD line and mode timer: holds one accepted item
// until the step logic takes it. Depends on lltm_pkg.
module lltm_in_reg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lltm_pkg::ELAPSED_W-1:0] in_tdata,
  input  logic                          take,
  output logic                          hold_valid,
  output logic [lltm_pkg::ELAPSED_W-1:0] hold_data
);
  import lltm_pkg::*;

  logic                 valid_r;
  logic [ELAPSED_W-1:0] data_r;

  // Accept when empty or when the held item moves on this cycle
  assign in_tready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= in_tdata;
    end
  end

  assign hold_valid = valid_r;
  assign hold_data  = data_r;

endmodule

@@ rtl/lltm_timing.sv @@
// Dot, line and mode state of the LCD line and mode timer, with the
// combinational step logic that builds each result. Depends on lltm_pkg.
module lltm_timing (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [lltm_pkg::ELAPSED_W-1:0] elapsed,
  input  lltm_pkg::cfg_t                cfg,
  output lltm_pkg::result_t             result
);
  import lltm_pkg::*;

  logic [DOT_W-1:0]  dot_r, dot_nxt;
  logic [LINE_W-1:0] line_r, line_nxt;
  mode_t             mode_r, mode_nxt;
  logic              match_r, match_nxt;

  logic [DOT_W:0]    dots_sum;
  logic [DOT_W:0]    dots_new;
  logic              wrap;
  logic [LINE_W:0]   next_line;
  mode_t             mode_mid;
  logic              vblank_irq, stat_irq, line_started;

  // Advance dots, then the line on wrap, then the mode from the dot position
  always_comb begin
    dots_sum     = {1'b0, dot_r} + {{(DOT_W+1-ELAPSED_W){1'b0}}, elapsed};
    wrap         = dots_sum >= (DOT_W+1)'(DOTS_PER_LINE);
    dots_new     = wrap ? dots_sum - (DOT_W+1)'(DOTS_PER_LINE) : dots_sum;
    next_line    = {1'b0, line_r} + (LINE_W+1)'(1);
    dot_nxt      = dot_r;
    line_nxt     = line_r;
    mode_mid     = mode_r;
    mode_nxt     = mode_r;
    match_nxt    = match_r;
    vblank_irq   = 1'b0;
    stat_irq     = 1'b0;
    line_started = 1'b0;

    if (cfg.lcd_enable) begin
      if (wrap) begin
        if (next_line == (LINE_W+1)'(VISIBLE_LINES)) begin
          mode_mid   = MODE_VBLANK;
          vblank_irq = 1'b1;
          if (cfg.stat_enables[STAT_EN_VBLANK]) stat_irq = 1'b1;
        end else if (next_line > (LINE_W+1)'(LAST_LINE)) begin
          next_line = '0;
          mode_mid  = MODE_OAM;
          if (cfg.stat_enables[STAT_EN_OAM]) stat_irq = 1'b1;
        end else if (next_line < (LINE_W+1)'(VISIBLE_LINES)) begin
          mode_mid = MODE_OAM;
          if (cfg.stat_enables[STAT_EN_OAM]) stat_irq = 1'b1;
        end
        line_nxt = next_line[LINE_W-1:0];
        if (line_nxt < LINE_W'(VISIBLE_LINES)) line_started = 1'b1;
        // Coincidence is sampled on each line advance
        if (line_nxt == cfg.lyc_value) begin
          match_nxt = 1'b1;
          if (cfg.stat_enables[STAT_EN_MATCH]) stat_irq = 1'b1;
        end else begin
          match_nxt = 1'b0;
        end
      end
      dot_nxt  = dots_new[DOT_W-1:0];
      mode_nxt = mode_mid;

      // Visible lines follow the dot position
      if (line_nxt < LINE_W'(VISIBLE_LINES)) begin
        if (dot_nxt < DOT_W'(OAM_SCAN_END)) begin
          mode_nxt = MODE_OAM;
        end else if (dot_nxt < DOT_W'(DRAW_END)) begin
          mode_nxt = MODE_DRAW;
        end else begin
          if (mode_mid != MODE_HBLANK && cfg.stat_enables[STAT_EN_HBLANK]) stat_irq = 1'b1;
          mode_nxt = MODE_HBLANK;
        end
      end
    end

    result.line_number  = line_nxt;
    result.lcd_mode     = mode_nxt;
    result.coincidence  = match_nxt;
    result.vblank_irq   = vblank_irq;
    result.stat_irq     = stat_irq;
    result.frame_done   = vblank_irq;
    result.line_started = line_started;
  end

  // Commit state when an item passes through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r   <= '0;
      line_r  <= '0;
      mode_r  <= MODE_HBLANK;
      match_r <= 1'b0;
    end else if (step) begin
      dot_r   <= dot_nxt;
      line_r  <= line_nxt;
      mode_r  <= mode_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

@@ rtl/lcd_line_and_mode_timer_core.sv @@
// LCD line and mode timer: an accepted item moves through the input register,
// then the result register; throughput one item per cycle unless the output
// stalls, set by the single add-compare-update of the dot and line state.
// Reset (rst_n low, synchronous) empties both registers, zeroes dot, line,
// mode and coincidence state, sets lcd_enable to 1 and the other registers to 0.
// Depends on lltm_pkg, lltm_cfg_regs, lltm_in_reg and lltm_timing.
module lcd_line_and_mode_timer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [7:0] elapsed_cycles
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [lltm_pkg::ELAPSED_W-1:0] in_tdata,
  // out_tdata: [7:0] line_number, [9:8] lcd_mode, [10] coincidence,
  // [11] vblank_irq, [12] stat_irq, [13] frame_done, [14] line_started,
  // [15] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lltm_pkg::OUT_W-1:0]    out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lltm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lltm_pkg::CFG_DAT_W-1:0] cfg_data
);
  import lltm_pkg::*;

  cfg_t                 cfg;
  logic                 hold_valid;
  logic [ELAPSED_W-1:0] hold_data;
  logic                 advance;
  logic                 step;
  result_t              result;
  logic                 out_valid_r;
  result_t              out_r;

  assign cfg_ready = 1'b1;

  lltm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The held item moves when the result register is free or draining
  assign advance = !out_valid_r || out_tready;
  assign step    = hold_valid && advance;

  lltm_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (advance),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  lltm_timing u_timing (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .elapsed (hold_data),
    .cfg     (cfg),
    .result  (result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r.line_started, out_r.frame_done, out_r.stat_irq,
                       out_r.vblank_irq, out_r.coincidence, out_r.lcd_mode,
                       out_r.line_number};

  // Line number stays inside the frame
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[7:0] <= LINE_W'(LAST_LINE))
    else $error("line number past last line");

  // Vblank pulse only on entry to the first vblank line, in vblank mode
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[11]) |->
      (out_tdata[7:0] == LINE_W'(VISIBLE_LINES) && out_tdata[9:8] == MODE_VBLANK
       && out_tdata[13]))
    else $error("vblank pulse outside vblank entry");

  // Line start pulse only on visible lines, and never with a vblank pulse
  a_line_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[14]) |->
      (out_tdata[7:0] < LINE_W'(VISIBLE_LINES) && !out_tdata[11]))
    else $error("line start pulse on a non-visible line");

  // An item that passes the step logic always reaches the result register
  a_step_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("stepped item lost before result register");

endmodule
